@@ rtl/tcw_pkg.sv @@
// tcw_pkg: shared types and constants for the text console writer.
// Used by tcw_front, tcw_queue, tcw_back and text_console_writer_with_scroll.
package tcw_pkg;

	localparam int SCREEN_COLUMNS_DEF = 80;
	localparam int SCREEN_LINES_DEF   = 25;

	localparam int MODE_W     = 2;
	localparam int VALUE_W    = 8;
	localparam int INDEX_W    = 11;
	localparam int LINE_OUT_W = 5;
	localparam int COL_OUT_W  = 7;

	localparam logic [7:0] RESET_ATTR   = 8'h0F;
	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] BLANK_CHAR   = 8'h00;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [MODE_W-1:0] {
		MODE_PRINT    = 2'd0,
		MODE_SET_ATTR = 2'd1,
		MODE_CLEAR    = 2'd2,
		MODE_READ     = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		OP_PRINT,
		OP_NEWLINE,
		OP_SET_ATTR,
		OP_CLEAR,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [VALUE_W-1:0] value;
		logic [INDEX_W-1:0] index;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_WRITE,
		ST_CLEAR,
		ST_CLR_DONE
	} state_t;

endpackage

@@ rtl/tcw_front.sv @@
// tcw_front: accepts input requests and classifies them into console commands.
// Depends on tcw_pkg (mode_t, op_t, cmd_t).
module tcw_front (
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tcw_pkg::MODE_W-1:0]  mode,
	input  logic [tcw_pkg::VALUE_W-1:0] value,
	input  logic [tcw_pkg::INDEX_W-1:0] cell_index,
	input  logic                        init_busy,
	input  logic                        q_ready,
	output logic                        q_push,
	output tcw_pkg::cmd_t               q_wdata
);

	tcw_pkg::op_t op;

	always_comb begin
		case (tcw_pkg::mode_t'(mode))
			tcw_pkg::MODE_PRINT: begin
				op = (value == tcw_pkg::NEWLINE_CODE) ? tcw_pkg::OP_NEWLINE : tcw_pkg::OP_PRINT;
			end
			tcw_pkg::MODE_SET_ATTR: op = tcw_pkg::OP_SET_ATTR;
			tcw_pkg::MODE_CLEAR:    op = tcw_pkg::OP_CLEAR;
			tcw_pkg::MODE_READ:     op = tcw_pkg::OP_READ;
			default:                op = tcw_pkg::OP_READ;
		endcase
	end

	// no requests until the power-up screen fill is done
	assign in_ready      = q_ready & ~init_busy;
	assign q_push        = in_valid & in_ready;
	assign q_wdata.op    = op;
	assign q_wdata.value = value;
	assign q_wdata.index = cell_index;

endmodule

@@ rtl/tcw_queue.sv @@
// tcw_queue: short command queue between the front and the back of the console.
// Depends on tcw_pkg (cmd_t, queue depth constants).
module tcw_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tcw_pkg::cmd_t wdata,
	output logic          not_full,
	input  logic          pop,
	output logic          not_empty,
	output tcw_pkg::cmd_t rdata
);

	tcw_pkg::cmd_t                entry_q [tcw_pkg::QUEUE_DEPTH];
	logic [tcw_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [tcw_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [tcw_pkg::QCNT_W-1:0]   count_q;

	assign not_full  = (count_q != tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/tcw_back.sv @@
// tcw_back: executes console commands against the screen memory and cursor.
// Screen is a ring of lines addressed through a top-line base. Depends on tcw_pkg.
module tcw_back #(
	parameter int COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
	parameter int LINES   = tcw_pkg::SCREEN_LINES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  tcw_pkg::cmd_t                  q_rdata,
	output logic                           q_pop,
	output logic                           init_busy,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           wrote_cell,
	output logic                           scrolled,
	output logic [tcw_pkg::LINE_OUT_W-1:0] line_now,
	output logic [tcw_pkg::COL_OUT_W-1:0]  column_now,
	output logic [7:0]                     cell_char,
	output logic [7:0]                     cell_attr
);

	localparam int CELLS  = COLUMNS * LINES;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int LIN_W  = $clog2(CELLS + 1);
	localparam int LINE_W = $clog2(LINES + 1);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int SUM_W  = ((LIN_W > tcw_pkg::INDEX_W) ? LIN_W : tcw_pkg::INDEX_W) + 1;
	localparam logic [SUM_W-1:0] CELLS_S = SUM_W'(CELLS);

	tcw_pkg::state_t state_q, state_d;

	logic [LINE_W-1:0] line_q;
	logic [COL_W-1:0]  col_q;
	logic [LIN_W-1:0]  lin_q;     // line_q * COLUMNS + col_q
	logic [ADDR_W-1:0] top_q;     // physical address of screen line zero
	logic [7:0]        attr_q;
	logic [7:0]        val_q;
	logic [ADDR_W-1:0] sweep_q;
	logic              rd_oor_q;
	logic [15:0]       rd_data_q;
	logic [15:0]       mem [CELLS];

	logic              out_valid_q;
	logic              wrote_q;
	logic              scrolled_q;
	logic [LINE_W-1:0] line_out_q;
	logic [COL_W-1:0]  col_out_q;
	logic [7:0]        char_out_q;
	logic [7:0]        attr_out_q;

	// combinational helpers
	logic              slot_free;
	logic [SUM_W-1:0]  wr_sum, rd_sum, rd_idx;
	logic [ADDR_W-1:0] wr_phys, rd_phys;
	logic              rd_oor;
	logic              col_last, at_bottom, scroll_end, cells_end, top_last;
	logic [COL_W-1:0]  adv_col;
	logic [LINE_W-1:0] adv_line, nl_line;
	logic [LIN_W-1:0]  adv_lin, nl_lin;

	// control
	logic              we, re, load_out, cur_ld, top_ld, attr_ld, val_ld, sweep_ld;
	logic [ADDR_W-1:0] waddr, sweep_d, top_d;
	logic [15:0]       wdata;
	logic [LINE_W-1:0] line_d;
	logic [COL_W-1:0]  col_d;
	logic [LIN_W-1:0]  lin_d;
	logic              res_wrote, res_scrolled;
	logic [7:0]        res_char, res_attr;

	assign slot_free = ~out_valid_q | out_ready;

	assign wr_sum  = SUM_W'(lin_q) + SUM_W'(top_q);
	assign wr_phys = ADDR_W'((wr_sum >= CELLS_S) ? wr_sum - CELLS_S : wr_sum);
	assign rd_idx  = SUM_W'(q_rdata.index);
	assign rd_oor  = (rd_idx >= CELLS_S);
	assign rd_sum  = rd_idx + SUM_W'(top_q);
	assign rd_phys = ADDR_W'((rd_sum >= CELLS_S) ? rd_sum - CELLS_S : rd_sum);

	assign col_last   = (col_q == COL_W'(COLUMNS - 1));
	assign adv_col    = col_last ? '0 : col_q + 1'b1;
	assign adv_line   = col_last ? line_q + 1'b1 : line_q;
	assign adv_lin    = lin_q + 1'b1;
	assign at_bottom  = (line_q == LINE_W'(LINES));
	assign nl_line    = at_bottom ? line_q : line_q + 1'b1;
	assign nl_lin     = at_bottom ? lin_q : lin_q - LIN_W'(col_q) + LIN_W'(COLUMNS);
	assign scroll_end = (sweep_q == top_q + ADDR_W'(COLUMNS - 1));
	assign cells_end  = (sweep_q == ADDR_W'(CELLS - 1));
	assign top_last   = (top_q == ADDR_W'(CELLS - COLUMNS));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tcw_pkg::ST_INIT: begin
				if (cells_end) state_d = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_IDLE: begin
				if (q_valid) begin
					case (q_rdata.op)
						tcw_pkg::OP_PRINT: if (at_bottom) state_d = tcw_pkg::ST_SCROLL;
						tcw_pkg::OP_CLEAR: state_d = tcw_pkg::ST_CLEAR;
						tcw_pkg::OP_READ:  state_d = tcw_pkg::ST_READ;
						default:           state_d = tcw_pkg::ST_IDLE;
					endcase
				end
			end
			tcw_pkg::ST_READ: begin
				if (slot_free) state_d = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_SCROLL: begin
				if (scroll_end) state_d = tcw_pkg::ST_WRITE;
			end
			tcw_pkg::ST_WRITE: begin
				if (slot_free) state_d = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_CLEAR: begin
				if (cells_end) state_d = tcw_pkg::ST_CLR_DONE;
			end
			tcw_pkg::ST_CLR_DONE: begin
				if (slot_free) state_d = tcw_pkg::ST_IDLE;
			end
			default: state_d = tcw_pkg::ST_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		q_pop        = 1'b0;
		we           = 1'b0;
		re           = 1'b0;
		load_out     = 1'b0;
		cur_ld       = 1'b0;
		top_ld       = 1'b0;
		attr_ld      = 1'b0;
		val_ld       = 1'b0;
		sweep_ld     = 1'b0;
		waddr        = sweep_q;
		wdata        = {tcw_pkg::BLANK_CHAR, attr_q};
		sweep_d      = sweep_q + 1'b1;
		top_d        = top_last ? '0 : top_q + ADDR_W'(COLUMNS);
		line_d       = line_q;
		col_d        = col_q;
		lin_d        = lin_q;
		res_wrote    = 1'b0;
		res_scrolled = 1'b0;
		res_char     = 8'h00;
		res_attr     = 8'h00;
		case (state_q)
			tcw_pkg::ST_INIT: begin
				we       = 1'b1;
				wdata    = {tcw_pkg::BLANK_CHAR, tcw_pkg::RESET_ATTR};
				sweep_ld = 1'b1;
				if (cells_end) sweep_d = '0;
			end
			tcw_pkg::ST_IDLE: begin
				if (q_valid) begin
					case (q_rdata.op)
						tcw_pkg::OP_PRINT: begin
							if (at_bottom) begin
								q_pop    = 1'b1;
								val_ld   = 1'b1;
								sweep_ld = 1'b1;
								sweep_d  = top_q;  // old top line becomes the blank bottom
							end else if (slot_free) begin
								q_pop     = 1'b1;
								we        = 1'b1;
								waddr     = wr_phys;
								wdata     = {q_rdata.value, attr_q};
								cur_ld    = 1'b1;
								line_d    = adv_line;
								col_d     = adv_col;
								lin_d     = adv_lin;
								load_out  = 1'b1;
								res_wrote = 1'b1;
							end
						end
						tcw_pkg::OP_NEWLINE: begin
							if (slot_free) begin
								q_pop    = 1'b1;
								cur_ld   = 1'b1;
								line_d   = nl_line;
								col_d    = '0;
								lin_d    = nl_lin;
								load_out = 1'b1;
							end
						end
						tcw_pkg::OP_SET_ATTR: begin
							if (slot_free) begin
								q_pop    = 1'b1;
								attr_ld  = 1'b1;
								load_out = 1'b1;
							end
						end
						tcw_pkg::OP_CLEAR: begin
							q_pop    = 1'b1;
							sweep_ld = 1'b1;
							sweep_d  = '0;
						end
						tcw_pkg::OP_READ: begin
							q_pop = 1'b1;
							re    = 1'b1;
						end
						default: ;
					endcase
				end
			end
			tcw_pkg::ST_READ: begin
				load_out = slot_free;
				res_char = rd_oor_q ? 8'h00 : rd_data_q[15:8];
				res_attr = rd_oor_q ? 8'h00 : rd_data_q[7:0];
			end
			tcw_pkg::ST_SCROLL: begin
				we       = 1'b1;
				sweep_ld = 1'b1;
				if (scroll_end) begin
					top_ld = 1'b1;
					cur_ld = 1'b1;
					line_d = LINE_W'(LINES - 1);
					col_d  = '0;
					lin_d  = LIN_W'((LINES - 1) * COLUMNS);
				end
			end
			tcw_pkg::ST_WRITE: begin
				if (slot_free) begin
					we           = 1'b1;
					waddr        = wr_phys;
					wdata        = {val_q, attr_q};
					cur_ld       = 1'b1;
					line_d       = adv_line;
					col_d        = adv_col;
					lin_d        = adv_lin;
					load_out     = 1'b1;
					res_wrote    = 1'b1;
					res_scrolled = 1'b1;
				end
			end
			tcw_pkg::ST_CLEAR: begin
				we       = 1'b1;
				sweep_ld = 1'b1;
				if (cells_end) begin
					sweep_d = '0;
					top_ld  = 1'b1;
					top_d   = '0;
					cur_ld  = 1'b1;
					line_d  = '0;
					col_d   = '0;
					lin_d   = '0;
				end
			end
			tcw_pkg::ST_CLR_DONE: begin
				load_out = slot_free;
			end
			default: ;
		endcase
	end

	// screen memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[rd_phys];
		end
	end

	always_ff @(posedge clk) begin
		if (val_ld) val_q <= q_rdata.value;
		if (load_out) begin
			wrote_q    <= res_wrote;
			scrolled_q <= res_scrolled;
			line_out_q <= line_d;
			col_out_q  <= col_d;
			char_out_q <= res_char;
			attr_out_q <= res_attr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcw_pkg::ST_INIT;
			line_q      <= '0;
			col_q       <= '0;
			lin_q       <= '0;
			top_q       <= '0;
			attr_q      <= tcw_pkg::RESET_ATTR;
			sweep_q     <= '0;
			rd_oor_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cur_ld) begin
				line_q <= line_d;
				col_q  <= col_d;
				lin_q  <= lin_d;
			end
			if (top_ld)   top_q    <= top_d;
			if (attr_ld)  attr_q   <= q_rdata.value;
			if (sweep_ld) sweep_q  <= sweep_d;
			if (re)       rd_oor_q <= rd_oor;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign init_busy  = (state_q == tcw_pkg::ST_INIT);
	assign out_valid  = out_valid_q;
	assign wrote_cell = wrote_q;
	assign scrolled   = scrolled_q;
	assign line_now   = tcw_pkg::LINE_OUT_W'(line_out_q);
	assign column_now = tcw_pkg::COL_OUT_W'(col_out_q);
	assign cell_char  = char_out_q;
	assign cell_attr  = attr_out_q;

	a_lin_matches_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		lin_q == LIN_W'(int'(line_q) * COLUMNS + int'(col_q)))
		else $error("linear cursor out of step with line and column");

	a_pending_scroll_col0: assert property (@(posedge clk) disable iff (!arst_n)
		at_bottom |-> (col_q == '0))
		else $error("cursor past bottom with nonzero column");

	a_top_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= ADDR_W'(CELLS - COLUMNS))
		else $error("top line base out of range");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == tcw_pkg::ST_IDLE && q_valid))
		else $error("command popped outside idle");

	a_no_result_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !out_valid_q)
		else $error("result shown during screen fill");

endmodule

@@ rtl/text_console_writer_with_scroll.sv @@
// text_console_writer_with_scroll: text console with cursor, attribute and one-line scroll.
// Instantiates tcw_front, tcw_queue and tcw_back; depends on tcw_pkg.
//
// Usage:
//   Requests enter on in_valid/in_ready with mode, value and cell_index; each request
//   gives exactly one result on out_valid/out_ready. A two-entry command queue sits
//   between the request decoder and the executor, and the result is held in an output
//   register, so new requests are taken while a result waits to be picked up.
//   A read uses the registered screen memory read; a print that scrolls first blanks
//   one line of the line ring, one cell write per cycle; clear blanks the whole screen, one
//   cell per cycle. Scrolling moves no data: a top-line base rotates over a ring of screen
//   lines. After reset the screen memory is filled with blank cells, one per cycle; in_ready
//   stays low during that fill. When the receiver holds out_ready low, the executor stops
//   at the next result and the queue fills, after which in_ready drops.
module text_console_writer_with_scroll #(
	parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_LINES   = tcw_pkg::SCREEN_LINES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [tcw_pkg::MODE_W-1:0]     mode,
	input  logic [tcw_pkg::VALUE_W-1:0]    value,
	input  logic [tcw_pkg::INDEX_W-1:0]    cell_index,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           wrote_cell,
	output logic                           scrolled,
	output logic [tcw_pkg::LINE_OUT_W-1:0] line_now,
	output logic [tcw_pkg::COL_OUT_W-1:0]  column_now,
	output logic [7:0]                     cell_char,
	output logic [7:0]                     cell_attr
);

	logic          init_busy;
	logic          q_ready, q_push, q_valid, q_pop;
	tcw_pkg::cmd_t q_wdata, q_rdata;

	tcw_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.value      (value),
		.cell_index (cell_index),
		.init_busy  (init_busy),
		.q_ready    (q_ready),
		.q_push     (q_push),
		.q_wdata    (q_wdata)
	);

	tcw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.not_full  (q_ready),
		.pop       (q_pop),
		.not_empty (q_valid),
		.rdata     (q_rdata)
	);

	tcw_back #(
		.COLUMNS (SCREEN_COLUMNS),
		.LINES   (SCREEN_LINES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_rdata    (q_rdata),
		.q_pop      (q_pop),
		.init_busy  (init_busy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.wrote_cell (wrote_cell),
		.scrolled   (scrolled),
		.line_now   (line_now),
		.column_now (column_now),
		.cell_char  (cell_char),
		.cell_attr  (cell_attr)
	);

endmodule

@@ verif/text_console_writer_with_scroll_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for text_console_writer_with_scroll: a short table of directed requests,
// then ~1000 random ones, checked against table results or a shadow model of screen and cursor.
// Depends on tcw_pkg and the RTL of text_console_writer_with_scroll only.
module text_console_writer_with_scroll_test;

	localparam int COLS        = tcw_pkg::SCREEN_COLUMNS_DEF;
	localparam int ROWS        = tcw_pkg::SCREEN_LINES_DEF;
	localparam int CELLS       = COLS * ROWS;
	localparam int TOTAL_ITEMS = 1000;
	localparam int CALM_ITEMS  = 150;
	localparam int LONG_HOLD   = 400;
	localparam int QUIET_LIMIT = 20000;
	localparam int REPORT_MAX  = 10;

	localparam tcw_pkg::mode_t M_PRINT = tcw_pkg::MODE_PRINT;
	localparam tcw_pkg::mode_t M_ATTR  = tcw_pkg::MODE_SET_ATTR;
	localparam tcw_pkg::mode_t M_CLEAR = tcw_pkg::MODE_CLEAR;
	localparam tcw_pkg::mode_t M_READ  = tcw_pkg::MODE_READ;
	localparam logic [7:0]     NL      = tcw_pkg::NEWLINE_CODE;

	typedef struct packed {
		logic                           wrote;
		logic                           scroll_hit;
		logic [tcw_pkg::LINE_OUT_W-1:0] line_pos;
		logic [tcw_pkg::COL_OUT_W-1:0]  col_pos;
		logic [7:0]                     ch;
		logic [7:0]                     attr;
	} console_result_t;

	typedef struct {
		tcw_pkg::mode_t  m;
		logic [7:0]      v;
		logic [10:0]     idx;
		bit              fixed;
		console_result_t res;
	} plan_row_t;

	localparam int DIR_ROWS = 24;

	// fixed rows: reset contents, extremes of the read index, first prints, newline, clear
	plan_row_t directed_plan [DIR_ROWS] = '{
		'{M_READ,  8'h00, 11'd0,    1'b1, '{1'b0, 1'b0, 5'd0, 7'd0, 8'h00, 8'h0F}},
		'{M_READ,  8'hFF, 11'd1999, 1'b1, '{1'b0, 1'b0, 5'd0, 7'd0, 8'h00, 8'h0F}},
		'{M_READ,  8'h00, 11'd2000, 1'b1, '{1'b0, 1'b0, 5'd0, 7'd0, 8'h00, 8'h00}},
		'{M_READ,  8'h00, 11'd2047, 1'b1, '{1'b0, 1'b0, 5'd0, 7'd0, 8'h00, 8'h00}},
		'{M_PRINT, 8'h00, 11'd0,    1'b1, '{1'b1, 1'b0, 5'd0, 7'd1, 8'h00, 8'h00}},
		'{M_PRINT, 8'hFF, 11'd2047, 1'b1, '{1'b1, 1'b0, 5'd0, 7'd2, 8'h00, 8'h00}},
		'{M_ATTR,  8'h00, 11'd0,    1'b1, '{1'b0, 1'b0, 5'd0, 7'd2, 8'h00, 8'h00}},
		'{M_PRINT, 8'h41, 11'd0,    1'b0, '0},
		'{M_ATTR,  8'hFF, 11'd0,    1'b0, '0},
		'{M_PRINT, 8'h55, 11'd0,    1'b0, '0},
		'{M_READ,  8'h00, 11'd0,    1'b0, '0},
		'{M_READ,  8'h00, 11'd3,    1'b0, '0},
		'{M_PRINT, NL,    11'd0,    1'b1, '{1'b0, 1'b0, 5'd1, 7'd0, 8'h00, 8'h00}},
		'{M_PRINT, 8'hAA, 11'd0,    1'b0, '0},
		'{M_PRINT, NL,    11'd0,    1'b0, '0},
		'{M_READ,  8'h00, 11'd80,   1'b0, '0},
		'{M_READ,  8'h00, 11'd81,   1'b0, '0},
		'{M_CLEAR, 8'h00, 11'd0,    1'b1, '{1'b0, 1'b0, 5'd0, 7'd0, 8'h00, 8'h00}},
		'{M_READ,  8'h00, 11'd0,    1'b0, '0},
		'{M_READ,  8'h00, 11'd1999, 1'b0, '0},
		'{M_ATTR,  8'h0F, 11'd0,    1'b0, '0},
		'{M_READ,  8'h00, 11'd1024, 1'b0, '0},
		'{M_PRINT, 8'h7F, 11'd0,    1'b0, '0},
		'{M_READ,  8'h00, 11'd1365, 1'b0, '0}
	};

	logic                           clk        = 1'b0;
	logic                           arst_n     = 1'b0;
	logic                           in_valid   = 1'b0;
	logic                           out_ready  = 1'b0;
	logic [tcw_pkg::MODE_W-1:0]     mode       = '0;
	logic [tcw_pkg::VALUE_W-1:0]    value      = '0;
	logic [tcw_pkg::INDEX_W-1:0]    cell_index = '0;
	logic                           in_ready;
	logic                           out_valid;
	logic                           wrote_cell;
	logic                           scrolled;
	logic [tcw_pkg::LINE_OUT_W-1:0] line_now;
	logic [tcw_pkg::COL_OUT_W-1:0]  column_now;
	logic [7:0]                     cell_char;
	logic [7:0]                     cell_attr;

	// shadow copy of the console
	logic [7:0] shadow_chars [CELLS];
	logic [7:0] shadow_attrs [CELLS];
	int         cur_line;
	int         cur_col;
	logic [7:0] cur_attr;

	console_result_t pending_results [$];
	console_result_t got;
	console_result_t want;

	int  mismatches;
	int  items_sent;
	int  results_seen;
	int  quiet_cycles;
	int  n_prints, n_scrolls, n_wraps, n_clears, n_reads, n_far_reads;
	bit  calm;
	bit  long_hold_req;

	text_console_writer_with_scroll u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.value      (value),
		.cell_index (cell_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.wrote_cell (wrote_cell),
		.scrolled   (scrolled),
		.line_now   (line_now),
		.column_now (column_now),
		.cell_char  (cell_char),
		.cell_attr  (cell_attr)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void reset_console();
		for (int i = 0; i < CELLS; i++) begin
			shadow_chars[i] = tcw_pkg::BLANK_CHAR;
			shadow_attrs[i] = tcw_pkg::RESET_ATTR;
		end
		cur_line = 0;
		cur_col  = 0;
		cur_attr = tcw_pkg::RESET_ATTR;
	endfunction

	// Advances the shadow console by one request and returns the result it should produce.
	function automatic console_result_t apply_request(input tcw_pkg::mode_t m,
			input logic [7:0] v, input logic [10:0] idx);
		console_result_t r;
		int pos;
		r = '0;
		case (m)
			M_PRINT: begin
				n_prints++;
				if (v == NL) begin
					// saturates one past the bottom: many newlines still cost one scroll
					if (cur_line < ROWS)
						cur_line++;
					cur_col = 0;
				end else begin
					if (cur_line >= ROWS) begin
						for (int i = 0; i < (ROWS - 1) * COLS; i++) begin
							shadow_chars[i] = shadow_chars[i + COLS];
							shadow_attrs[i] = shadow_attrs[i + COLS];
						end
						for (int i = (ROWS - 1) * COLS; i < CELLS; i++) begin
							shadow_chars[i] = tcw_pkg::BLANK_CHAR;
							shadow_attrs[i] = cur_attr;
						end
						cur_line     = ROWS - 1;
						cur_col      = 0;
						r.scroll_hit = 1'b1;
						n_scrolls++;
					end
					pos = cur_line * COLS + cur_col;
					shadow_chars[pos] = v;
					shadow_attrs[pos] = cur_attr;
					r.wrote = 1'b1;
					cur_col++;
					if (cur_col >= COLS) begin
						cur_col = 0;
						cur_line++;
						n_wraps++;
					end
				end
			end
			M_ATTR: cur_attr = v;
			M_CLEAR: begin
				for (int i = 0; i < CELLS; i++) begin
					shadow_chars[i] = tcw_pkg::BLANK_CHAR;
					shadow_attrs[i] = cur_attr;
				end
				cur_line = 0;
				cur_col  = 0;
				n_clears++;
			end
			default: begin
				n_reads++;
				if (idx < CELLS) begin
					r.ch   = shadow_chars[idx];
					r.attr = shadow_attrs[idx];
				end else begin
					n_far_reads++;
				end
			end
		endcase
		r.line_pos = cur_line[tcw_pkg::LINE_OUT_W-1:0];
		r.col_pos  = cur_col[tcw_pkg::COL_OUT_W-1:0];
		return r;
	endfunction

	function automatic void report_failure(input string what);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("ERROR @%0t: %s", $realtime, what);
	endfunction

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_request(input tcw_pkg::mode_t m, input logic [7:0] v,
			input logic [10:0] idx, input bit has_fixed, input console_result_t fixed_res);
		console_result_t predicted;
		// no idling on either side over the last stretch of the run
		if (items_sent >= TOTAL_ITEMS - CALM_ITEMS)
			calm = 1'b1;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		value      <= v;
		cell_index <= idx;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = apply_request(m, v, idx);
		pending_results.push_back(has_fixed ? fixed_res : predicted);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_plain(input tcw_pkg::mode_t m, input logic [7:0] v,
			input logic [10:0] idx);
		send_request(m, v, idx, 1'b0, '0);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Mostly runs of text and newlines so the cursor reaches the bottom and scrolls often.
	task automatic random_traffic(input int target);
		int  kind;
		int  n;
		int  near_idx;
		bit  held;
		bit  paused;
		held   = 1'b0;
		paused = 1'b0;
		while (items_sent < target) begin
			if (!held && items_sent >= DIR_ROWS + 300) begin
				long_hold_req = 1'b1;
				held          = 1'b1;
			end
			if (!paused && items_sent >= DIR_ROWS + 600) begin
				wait_drained();
				paused = 1'b1;
			end
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				n = $urandom_range(1, 100);
				if ($urandom_range(0, 9) == 0)
					n = $urandom_range(150, 260);
				if (n > target - items_sent)
					n = target - items_sent;
				repeat (n)
					send_plain(M_PRINT, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
				if (items_sent < target && $urandom_range(0, 1) == 1)
					send_plain(M_PRINT, NL, 11'($urandom_range(0, 2047)));
			end else if (kind < 55) begin
				n = $urandom_range(1, 30);
				if (n > target - items_sent)
					n = target - items_sent;
				repeat (n)
					send_plain(M_PRINT, NL, 11'($urandom_range(0, 2047)));
			end else if (kind < 65) begin
				send_plain(M_ATTR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
			end else if (kind < 80) begin
				n = $urandom_range(1, 4);
				if (n > target - items_sent)
					n = target - items_sent;
				repeat (n) begin
					if ($urandom_range(0, 1) == 1) begin
						// just behind the cursor, where the latest writes landed
						near_idx = cur_line * COLS + cur_col - $urandom_range(1, COLS);
						if (near_idx < 0)
							near_idx = 0;
					end else if ($urandom_range(0, 9) == 0) begin
						near_idx = $urandom_range(CELLS, 2047);
					end else begin
						near_idx = $urandom_range(0, CELLS - 1);
					end
					send_plain(M_READ, 8'($urandom_range(0, 255)), 11'(near_idx));
				end
			end else if (kind < 84) begin
				send_plain(M_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
			end else begin
				n = $urandom_range(0, 3);
				if (n == M_CLEAR && $urandom_range(0, 3) != 0)
					n = M_READ;
				send_plain(tcw_pkg::mode_t'(n), 8'($urandom_range(0, 255)),
					11'($urandom_range(0, 2047)));
			end
		end
	endtask

	// result side: random stalls, one long hold-off on request from the sender
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			got = {wrote_cell, scrolled, line_now, column_now, cell_char, cell_attr};
			if (pending_results.size() == 0) begin
				report_failure("result with no request pending");
			end else begin
				want = pending_results.pop_front();
				if (got !== want)
					report_failure($sformatf({"result %0d: wrote %b/%b scrolled %b/%b line %0d/%0d ",
						"column %0d/%0d char %h/%h attr %h/%h (expected/actual)"}, results_seen,
						want.wrote, got.wrote, want.scroll_hit, got.scroll_hit,
						want.line_pos, got.line_pos, want.col_pos, got.col_pos,
						want.ch, got.ch, want.attr, got.attr));
			end
		end
	end

	// ends the run if neither side moves for too long (covers the post-reset fill and clears)
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
				$display("text_console_writer_with_scroll verification failed");
				$finish;
			end
		end
	end

	initial begin
		mismatches    = 0;
		items_sent    = 0;
		results_seen  = 0;
		quiet_cycles  = 0;
		calm          = 1'b0;
		long_hold_req = 1'b0;
		reset_console();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int i = 0; i < DIR_ROWS; i++)
			send_request(directed_plan[i].m, directed_plan[i].v, directed_plan[i].idx,
				directed_plan[i].fixed, directed_plan[i].res);
		random_traffic(TOTAL_ITEMS);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (COLS + 20) @(posedge clk);
		if (pending_results.size() != 0)
			report_failure("results still pending at end of run");
		$display("%0d requests, %0d results: %0d prints, %0d scrolls, %0d line wraps,",
			items_sent, results_seen, n_prints, n_scrolls, n_wraps);
		$display("%0d clears, %0d reads (%0d past the last cell), %0d mismatches",
			n_clears, n_reads, n_far_reads, mismatches);
		if (mismatches == 0)
			$display("text_console_writer_with_scroll verification clean");
		else
			$display("text_console_writer_with_scroll verification failed");
		$finish;
	end

endmodule
